### rtl/lcm_with_overflow_check_macros.svh
// Assertion macros used by the checker in lcm_chk.sv.
`ifndef LCM_WITH_OVERFLOW_CHECK_MACROS_SVH
`define LCM_WITH_OVERFLOW_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCM_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/lcm_pkg.sv
package lcm_pkg;

    localparam int DATA_WIDTH = 32;
    // magnitude bits of a positive operand
    localparam int MAG_WIDTH  = DATA_WIDTH - 1;
    localparam int PROD_WIDTH = 2 * MAG_WIDTH;
    localparam int CNT_WIDTH  = $clog2(MAG_WIDTH + 1);

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic mul;
        logic wr;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic gcd_done;
        logic div_done;
    } t_sts;

endpackage

### rtl/lcm_dp.sv
module lcm_dp (
    input  logic                               i_clk,
    input  lcm_pkg::t_cmd                      i_cmd,
    input  logic [lcm_pkg::DATA_WIDTH-1:0]     i_first_value,
    input  logic [lcm_pkg::DATA_WIDTH-1:0]     i_second_value,
    output lcm_pkg::t_sts                      o_sts,
    output logic [lcm_pkg::MAG_WIDTH-1:0]      o_lcm_value,
    output logic                               o_error
);

    localparam int MW = lcm_pkg::MAG_WIDTH;
    localparam int DW = lcm_pkg::DATA_WIDTH;
    localparam int PW = lcm_pkg::PROD_WIDTH;
    localparam int CW = lcm_pkg::CNT_WIDTH;

    logic [MW-1:0] r_x, r_a, r_b, r_bq, r_quo, r_rem, r_lcm;
    logic [MW-1:0] n_a, n_b, n_bq, n_quo, n_rem;
    logic [PW-1:0] r_prod;
    logic [CW-1:0] r_cnt;
    logic          r_bad, r_err, n_bad, ovf;
    logic [MW:0]   rem_sh, diff;
    logic [MW-1:0] a_sub_b, b_sub_a;

    assign n_bad = (i_first_value == '0) || i_first_value[DW-1] ||
                   (i_second_value == '0) || i_second_value[DW-1];

    assign a_sub_b = r_a - r_b;
    assign b_sub_a = r_b - r_a;

    // binary gcd step; common factors of two are stripped from the dividend too
    always_comb begin
        n_a  = r_a;
        n_b  = r_b;
        n_bq = r_bq;
        priority if (!r_a[0] && !r_b[0]) begin
            n_a  = r_a >> 1;
            n_b  = r_b >> 1;
            n_bq = r_bq >> 1;
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a > r_b) begin
            n_a = a_sub_b >> 1;
        end else begin
            n_b = b_sub_a >> 1;
        end
    end

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[MW-1]};
    assign diff   = rem_sh - {1'b0, r_a};

    always_comb begin
        if (diff[MW]) begin
            n_rem = rem_sh[MW-1:0];
            n_quo = {r_quo[MW-2:0], 1'b0};
        end else begin
            n_rem = diff[MW-1:0];
            n_quo = {r_quo[MW-2:0], 1'b1};
        end
    end

    assign ovf = |r_prod[PW-1:MW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_first_value[MW-1:0];
            r_a   <= i_first_value[MW-1:0];
            r_b   <= i_second_value[MW-1:0];
            r_bq  <= i_second_value[MW-1:0];
            r_bad <= n_bad;
        end
        if (i_cmd.gcd_step) begin
            r_a  <= n_a;
            r_b  <= n_b;
            r_bq <= n_bq;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_bq;
            r_cnt <= CW'(MW);
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_x) * PW'(r_quo);
        end
        if (i_cmd.wr) begin
            r_err <= r_bad || ovf;
            r_lcm <= (r_bad || ovf) ? '0 : r_prod[MW-1:0];
        end
    end

    assign o_sts.bad      = r_bad;
    assign o_sts.gcd_done = (r_a == r_b);
    assign o_sts.div_done = (r_cnt == '0);
    assign o_lcm_value    = r_lcm;
    assign o_error        = r_err;

endmodule

### rtl/lcm_ctrl.sv
module lcm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  lcm_pkg::t_sts i_sts,
    output lcm_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GCD;
                end
            end
            S_GCD: begin
                // bad operands skip straight to the result write
                priority if (i_sts.bad) begin
                    n_state = S_WR;
                end else if (i_sts.gcd_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                if (out_free) begin
                    o_cmd.wr    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/lcm_with_overflow_check.sv
// Sequence: a non-positive operand goes from load straight to the write; otherwise the steps are:
//   load, binary gcd (shift/subtract steps), bit-serial division, multiply, write.
// Throughput: one word at a time; the next word is taken once the result is in the output register.
// The gcd loop and the one-bit-per-cycle divider take most of the time per word.
// Reset (synchronous, active low) returns the controller to idle and drops o_out_valid.
module lcm_with_overflow_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [lcm_pkg::DATA_WIDTH-1:0]     i_first_value,
    input  logic [lcm_pkg::DATA_WIDTH-1:0]     i_second_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [lcm_pkg::MAG_WIDTH-1:0]      o_lcm_value,
    output logic                               o_error
);

    lcm_pkg::t_cmd cmd;
    lcm_pkg::t_sts sts;

    lcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lcm_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_sts          (sts),
        .o_lcm_value    (o_lcm_value),
        .o_error        (o_error)
    );

endmodule

### rtl/lcm_chk.sv
`include "lcm_with_overflow_check_macros.svh"

module lcm_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [lcm_pkg::MAG_WIDTH-1:0]      o_lcm_value,
    input logic                               o_error
);

    logic                          in_take;
    logic                          out_held;
    logic                          out_bad;
    logic                          out_ok;
    logic [lcm_pkg::MAG_WIDTH:0]   out_word;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;
    assign out_bad  = o_out_valid && o_error;
    assign out_ok   = o_out_valid && !o_error;
    assign out_word = {o_lcm_value, o_error};

    // a held result word must not move
    `LCM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))

    // one word in flight: intake closes right after an accept
    `LCM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, o_in_stall)

    `LCM_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, out_bad, o_lcm_value == '0)

    // a good lcm of positive operands is never zero
    `LCM_ASSERT_NOW(a_ok_nonzero, i_clk, i_rst_n, out_ok, o_lcm_value != '0)

endmodule

bind lcm_with_overflow_check lcm_chk u_lcm_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_lcm_value    (o_lcm_value),
    .o_error        (o_error)
);
